[src/atccu_pkg.sv]
// Package: shared widths, constants and types of the affine chain composer.
`timescale 1ns / 1ps

package atccu_pkg;

  // Default number format of the stored composite
  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  // Fixed field widths of the stream items
  localparam int unsigned FIELD_W     = 32;
  localparam int unsigned ACC_W       = 64;
  localparam int unsigned DIM         = 3;
  localparam int unsigned ROW_W       = 2;
  localparam int unsigned TDATA_W     = 4 * FIELD_W;
  localparam int unsigned IN_TUSER_W  = ROW_W;
  localparam int unsigned OUT_TUSER_W = ROW_W + 1;

  // Row codes
  localparam logic [ROW_W-1:0] ROW_FIRST = 2'd0;
  localparam logic [ROW_W-1:0] ROW_LAST  = 2'd2;

  // Identity pattern, bit r*3+c set where the basis holds one
  localparam logic [DIM*DIM-1:0] IDENT_PAT = 9'b100_010_001;

  // Saturated or clamped value together with its overflow flag
  typedef struct packed {
    logic                    ovf;
    logic signed [ACC_W-1:0] sum;
  } sat_t;

endpackage

[src/affine_transform_chain_composer_unit.sv]
// Top level: composes a stream of 3D affine transforms into one, Q-format fixed point.
`timescale 1ns / 1ps

// Each local transform enters as three row items (tuser = row index, tlast = last
// transform of the chain). Rows are accepted in consecutive cycles unless a pending
// commit keeps the current item in the input register; there each row does twelve
// multiply-accumulates against the running composite. After the third row the
// composite is rounded, clamped and committed while the next item waits in the
// input register. On a chain end the three composed rows leave on consecutive
// cycles while m_axis_tready_i is high, from a result buffer (tlast on row 2,
// tuser bit 2 the sticky overflow flag); a chain end waits to commit while the
// previous result rows are still in that buffer. Overflow of an accumulator, of the
// rounding or of the final clamp saturates and sets the sticky flag, as does a row
// index out of order (the item is then taken as the expected row).
module affine_transform_chain_composer_unit
  import atccu_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // local_col0 [31:0], local_col1 [63:32], local_col2 [95:64], local_pos [127:96]
  input  logic [TDATA_W-1:0]     s_axis_tdata_i,
  // inner_index [1:0]
  input  logic [IN_TUSER_W-1:0]  s_axis_tuser_i,
  // chain_end
  input  logic                   s_axis_tlast_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // out_col0 [31:0], out_col1 [63:32], out_col2 [95:64], out_trans [127:96]
  output logic [TDATA_W-1:0]     m_axis_tdata_o,
  // out_row [1:0], overflow [2]
  output logic [OUT_TUSER_W-1:0] m_axis_tuser_o,
  // last_row
  output logic                   m_axis_tlast_o
);

  localparam int unsigned PROD_W = DATA_WIDTH + FIELD_W;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] HALF =
    {{(ACC_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] DATA_HI =
    {{(ACC_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] DATA_LO =
    {{(ACC_W-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] ONE_RAW =
    {{(ACC_W-1){1'b0}}, 1'b1} << FRAC_BITS;
  localparam logic signed [ACC_W-1:0] ONE_CLAMPED =
    (ONE_RAW > DATA_HI) ? DATA_HI : ONE_RAW;
  localparam logic signed [DATA_WIDTH-1:0] ONE = ONE_CLAMPED[DATA_WIDTH-1:0];

  // Saturating 64-bit add
  function automatic sat_t sat_add(input logic signed [ACC_W-1:0] a,
                                   input logic signed [ACC_W-1:0] b);
    sat_t                    res;
    logic signed [ACC_W-1:0] s;
    s       = a + b;
    res.ovf = (a[ACC_W-1] == b[ACC_W-1]) && (s[ACC_W-1] != a[ACC_W-1]);
    res.sum = res.ovf ? (a[ACC_W-1] ? ACC_MIN : ACC_MAX) : s;
    return res;
  endfunction

  // Clamp to the stored data range
  function automatic sat_t clamp_data(input logic signed [ACC_W-1:0] v);
    sat_t res;
    res.ovf = (v > DATA_HI) || (v < DATA_LO);
    res.sum = (v > DATA_HI) ? DATA_HI : ((v < DATA_LO) ? DATA_LO : v);
    return res;
  endfunction

  // Input register
  logic                         in_vld_q;
  logic [ROW_W-1:0]             in_idx_q;
  logic signed [FIELD_W-1:0]    in_l_q [DIM];
  logic signed [FIELD_W-1:0]    in_p_q;
  logic                         in_end_q;

  // Composite, accumulators and control
  logic signed [DATA_WIDTH-1:0] comp_b_q [DIM][DIM];
  logic signed [DATA_WIDTH-1:0] comp_t_q [DIM];
  logic signed [ACC_W-1:0]      part_b_q [DIM][DIM];
  logic signed [ACC_W-1:0]      part_t_q [DIM];
  logic [ROW_W-1:0]             exp_q;
  logic                         err_q;
  logic                         cm_pend_q;
  logic                         cm_end_q;

  // Result buffer
  logic                         out_busy_q;
  logic [ROW_W-1:0]             out_row_q;
  logic                         out_err_q;
  logic signed [DATA_WIDTH-1:0] out_b_q [DIM][DIM];
  logic signed [DATA_WIDTH-1:0] out_t_q [DIM];

  logic                         in_hs;
  logic                         mac_fire;
  logic                         cm_fire;
  logic                         out_hs;
  logic                         idx_err;

  logic signed [ACC_W-1:0]      mac_b [DIM][DIM];
  logic signed [ACC_W-1:0]      mac_t [DIM];
  logic                         mac_ovf;
  logic signed [DATA_WIDTH-1:0] cm_b [DIM][DIM];
  logic signed [DATA_WIDTH-1:0] cm_t [DIM];
  logic                         cm_ovf;

  // Handshakes: a row waits while a commit is pending
  assign mac_fire        = in_vld_q && !cm_pend_q;
  assign s_axis_tready_o = !in_vld_q || mac_fire;
  assign in_hs           = s_axis_tvalid_i && s_axis_tready_o;
  assign cm_fire         = cm_pend_q && (!cm_end_q || !out_busy_q);
  assign out_hs          = out_busy_q && m_axis_tready_i;
  assign idx_err         = (in_idx_q != exp_q);

  // Multiply the current composite column (slot 0) by the local row, accumulate
  always_comb begin : mac_calc
    logic signed [PROD_W-1:0] prod;
    sat_t                     sa;
    mac_ovf = 1'b0;
    for (int r = 0; r < DIM; r++) begin
      for (int c = 0; c < DIM; c++) begin
        prod        = comp_b_q[r][0] * in_l_q[c];
        sa          = sat_add(part_b_q[r][c], ACC_W'(prod));
        mac_b[r][c] = sa.sum;
        mac_ovf     = mac_ovf | sa.ovf;
      end
      prod     = comp_b_q[r][0] * in_p_q;
      sa       = sat_add(part_t_q[r], ACC_W'(prod));
      mac_t[r] = sa.sum;
      mac_ovf  = mac_ovf | sa.ovf;
    end
  end

  // Round half up, shift down, add old translation, clamp
  always_comb begin : commit_calc
    sat_t                    rnd;
    sat_t                    cl;
    logic signed [ACC_W-1:0] shv;
    cm_ovf = 1'b0;
    for (int r = 0; r < DIM; r++) begin
      for (int c = 0; c < DIM; c++) begin
        rnd        = sat_add(part_b_q[r][c], HALF);
        shv        = rnd.sum;
        shv        = shv >>> FRAC_BITS;
        cl         = clamp_data(shv);
        cm_b[r][c] = cl.sum[DATA_WIDTH-1:0];
        cm_ovf     = cm_ovf | rnd.ovf | cl.ovf;
      end
      rnd     = sat_add(part_t_q[r], HALF);
      shv     = rnd.sum;
      shv     = (shv >>> FRAC_BITS) + ACC_W'(comp_t_q[r]);
      cl      = clamp_data(shv);
      cm_t[r] = cl.sum[DATA_WIDTH-1:0];
      cm_ovf  = cm_ovf | rnd.ovf | cl.ovf;
    end
  end

  // Hold the accepted item
  always_ff @(posedge clk_i) begin
    if (in_hs) begin
      in_idx_q <= s_axis_tuser_i[ROW_W-1:0];
      for (int c = 0; c < DIM; c++) begin
        in_l_q[c] <= s_axis_tdata_i[c*FIELD_W +: FIELD_W];
      end
      in_p_q   <= s_axis_tdata_i[DIM*FIELD_W +: FIELD_W];
      in_end_q <= s_axis_tlast_i;
    end
  end

  // Control, composite and accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      exp_q      <= ROW_FIRST;
      err_q      <= 1'b0;
      cm_pend_q  <= 1'b0;
      cm_end_q   <= 1'b0;
      out_busy_q <= 1'b0;
      out_row_q  <= ROW_FIRST;
      for (int r = 0; r < DIM; r++) begin
        for (int c = 0; c < DIM; c++) begin
          comp_b_q[r][c] <= IDENT_PAT[r*DIM+c] ? ONE : '0;
          part_b_q[r][c] <= '0;
        end
        comp_t_q[r] <= '0;
        part_t_q[r] <= '0;
      end
    end else begin
      if (in_hs) begin
        in_vld_q <= 1'b1;
      end else if (mac_fire) begin
        in_vld_q <= 1'b0;
      end

      // Accumulate one row and rotate the next composite column into slot 0
      if (mac_fire) begin
        for (int r = 0; r < DIM; r++) begin
          for (int c = 0; c < DIM; c++) begin
            part_b_q[r][c] <= mac_b[r][c];
          end
          part_t_q[r]    <= mac_t[r];
          comp_b_q[r][0] <= comp_b_q[r][1];
          comp_b_q[r][1] <= comp_b_q[r][2];
          comp_b_q[r][2] <= comp_b_q[r][0];
        end
        err_q <= err_q | idx_err | mac_ovf;
        if (exp_q == ROW_LAST) begin
          exp_q     <= ROW_FIRST;
          cm_pend_q <= 1'b1;
          cm_end_q  <= in_end_q;
        end else begin
          exp_q <= exp_q + 2'd1;
        end
      end

      // Commit the composite; on chain end return to identity
      if (cm_fire) begin
        cm_pend_q <= 1'b0;
        for (int r = 0; r < DIM; r++) begin
          for (int c = 0; c < DIM; c++) begin
            comp_b_q[r][c] <= cm_end_q ? (IDENT_PAT[r*DIM+c] ? ONE : '0) : cm_b[r][c];
            part_b_q[r][c] <= '0;
          end
          comp_t_q[r] <= cm_end_q ? '0 : cm_t[r];
          part_t_q[r] <= '0;
        end
        err_q <= cm_end_q ? 1'b0 : (err_q | cm_ovf);
      end

      // Result rows
      if (cm_fire && cm_end_q) begin
        out_busy_q <= 1'b1;
        out_row_q  <= ROW_FIRST;
      end else if (out_hs) begin
        out_row_q <= out_row_q + 2'd1;
        if (out_row_q == ROW_LAST) begin
          out_busy_q <= 1'b0;
        end
      end
    end
  end

  // Load the result buffer, advance it one row per delivered item
  always_ff @(posedge clk_i) begin
    if (cm_fire && cm_end_q) begin
      out_err_q <= err_q | cm_ovf;
      out_b_q   <= cm_b;
      out_t_q   <= cm_t;
    end else if (out_hs) begin
      for (int k = 0; k < DIM - 1; k++) begin
        out_b_q[k] <= out_b_q[k+1];
        out_t_q[k] <= out_t_q[k+1];
      end
    end
  end

  // Drive the result item
  assign m_axis_tvalid_o = out_busy_q;
  assign m_axis_tdata_o  = {FIELD_W'(out_t_q[0]), FIELD_W'(out_b_q[0][2]),
                            FIELD_W'(out_b_q[0][1]), FIELD_W'(out_b_q[0][0])};
  assign m_axis_tuser_o  = {out_err_q, out_row_q};
  assign m_axis_tlast_o  = (out_row_q == ROW_LAST);

`ifndef SYNTH
  // The expected row never leaves the range of a transform
  assert property (@(posedge clk_i) disable iff (!rst_ni) exp_q != 2'd3)
    else $error("expected row index out of range");

  // A chain-end commit starts a fresh result burst at row 0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cm_fire && cm_end_q) |=> (out_busy_q && out_row_q == ROW_FIRST))
    else $error("result burst did not start at row 0");

  // After a chain-end commit the sticky flag is clear and the next row is row 0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cm_fire && cm_end_q) |=> (!err_q && exp_q == ROW_FIRST))
    else $error("chain state not cleared after chain end");

  // A commit is only requested by the third row of a transform
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(cm_pend_q) |-> ($past(exp_q) == ROW_LAST && exp_q == ROW_FIRST))
    else $error("commit requested before the third row");

  // The result buffer never delivers beyond the third row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_busy_q |-> (out_row_q != 2'd3))
    else $error("result row index out of range");
`endif

endmodule
